### hw/rtl/aip_pkg.sv
// Package for the amplitude invert polar unit: types, codes and helper functions.
`timescale 1ns / 1ps
package aip_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic [1:0] REG_COMPLEX_MODE  = 2'd0;
	localparam logic [1:0] REG_SUBTRACT_MODE = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEC,
		ST_MA,
		ST_MAH,
		ST_AMP,
		ST_DIV,
		ST_POST,
		ST_ROT,
		ST_MX,
		ST_MXH,
		ST_MX2,
		ST_MY,
		ST_MYH,
		ST_MY2,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               cmd;
		logic               first_of_set;
		logic               skip;
		logic signed [31:0] real_in;
		logic signed [31:0] imag_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] real_out;
		logic signed [31:0] imag_out;
		logic               max_zero_error;
		logic               saturated;
	} out_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               clip;
	} sat_t;

	// x result of vectoring (2^30, 0), used to derive the gain correction
	function automatic logic [63:0] cordic_gain(input int steps);
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		x = 64'sd1 <<< 30;
		y = 64'sd0;
		for (int i = 0; i < steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
			end else begin
				x = x - ys;
				y = y + xs;
			end
		end
		return x;
	endfunction

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.val  = 32'sh7FFFFFFF;
			r.clip = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val  = 32'sh80000000;
			r.clip = 1'b1;
		end else begin
			r.val  = v[31:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

### hw/rtl/amplitude_invert_polar_unit.sv
// Amplitude invert polar unit: sequencer around one shared CORDIC, multiply and divide datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready/in_data carries one sample word per item.
//   cmd 0 is a scan word that updates the running maximum and gives no result;
//   cmd 1 is a transform word that gives exactly one result word on
//   out_valid/out_ready/out_data.
//   The config port (cfg_we, cfg_index, cfg_wdata) sets complex_mode and
//   subtract_mode; write it only while the unit is idle.
// Sequencing:
//   One word at a time. in_ready is high only in the idle state; each word
//   runs the steps below and then returns to idle.
//   Real transform: setup, 64 divider steps, post, hand-over; a reciprocal
//   of zero skips the divider steps. The divider loop is the bulk of the work.
//   Complex transform: CORDIC_STEPS vectoring steps, gain multiply (ST_MA,
//   ST_MAH), setup, 64 divider steps, post, CORDIC_STEPS rotation steps,
//   gain multiply of x and y (ST_MX to ST_MY2), hand-over. Scan words: real
//   only the amplitude step, complex vectoring and gain multiply before it.
//   Skipped or error transforms go straight to hand-over; skipped scans stay idle.
// Reset: arst_n clears the running maximum, both mode bits and all control.
// Stall: the result sits in an output register; the next word is taken while
//   it waits, and the unit holds in its last step until the register frees.
module amplitude_invert_polar_unit #(
	parameter int FRAC_BITS    = aip_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = aip_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  aip_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output aip_pkg::out_t out_data
);

	localparam int W   = 45;
	localparam int ML  = 23;
	localparam int NW  = 64;
	localparam int DVW = 36;
	localparam int CW  = $clog2(NW + 1);
	localparam int SW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [63:0] GAIN  = aip_pkg::cordic_gain(CORDIC_STEPS);
	localparam logic [29:0] INV_K = 30'(((64'd1 << 60) + GAIN / 2) / GAIN);
	localparam logic signed [63:0] CLAMP = 64'sd1 <<< 40;

	aip_pkg::state_t state_q, state_d;

	logic                    complex_q, subtract_q;
	logic [31:0]             max_q;
	logic                    cmd_q, skip_q, err_q;
	logic signed [31:0]      re_q, im_q;
	logic signed [W-1:0]     x_q, y_q;
	logic [CORDIC_STEPS-1:0] dirs_q;
	logic                    flip_q;
	logic [CW-1:0]           cnt_q;
	logic [W+29:0]           prod_q;
	logic                    sgn_q;
	logic [NW-1:0]           dvd_q;
	logic [DVW-1:0]          ud_q;
	logic [DVW:0]            rem_q;
	logic                    neg_q;
	logic signed [31:0]      ro_q, io_q;
	logic                    sat_q;
	logic                    out_valid_q;
	aip_pkg::out_t           out_q;

	logic                    in_fire;
	logic                    out_free;
	logic                    cordic_last;
	logic signed [W-1:0]     xs, ys, mul_src;
	logic [W-1:0]            mag;
	logic                    mul_hi;
	logic [ML-1:0]           mul_part;
	logic [ML+29:0]          part_prod;
	logic [W-1:0]            rnd;
	logic signed [W:0]       rval;
	logic signed [63:0]      a_cur;
	logic signed [65:0]      diff, num;
	logic signed [65:0]      den;
	logic [63:0]             un;
	logic [DVW-1:0]          ud;
	logic [DVW:0]            rem_sh;
	logic                    q_bit;
	logic signed [63:0]      b_val, b_clamp;
	aip_pkg::sat_t           sat_b, sat_r;

	assign in_fire     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign cordic_last = (cnt_q == CW'(CORDIC_STEPS - 1));

	assign xs      = x_q >>> cnt_q;
	assign ys      = y_q >>> cnt_q;
	assign mul_src = (state_q == aip_pkg::ST_MY || state_q == aip_pkg::ST_MYH) ? y_q : x_q;
	assign mag     = mul_src[W-1] ? W'(-mul_src) : W'(mul_src);

	// gain multiply in two halves: low bits first, high bits added shifted
	assign mul_hi    = (state_q == aip_pkg::ST_MAH) || (state_q == aip_pkg::ST_MXH) ||
	                   (state_q == aip_pkg::ST_MYH);
	assign mul_part  = mul_hi ? ML'(mag[W-1:ML]) : mag[ML-1:0];
	assign part_prod = mul_part * INV_K;

	assign rnd     = W'((prod_q + (W+30)'(1 << 29)) >> 30);
	assign rval    = sgn_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

	// amplitude: corrected magnitude in complex mode, the sample itself otherwise
	assign a_cur = complex_q ? 64'(rval) : 64'(re_q);

	// divider operands, signed numerator over signed denominator
	always_comb begin
		diff = $signed({34'd0, max_q}) - 66'(a_cur);
		if (subtract_q) begin
			num = (diff <<< (FRAC_BITS + 3)) + (diff <<< (FRAC_BITS + 1));
			den = $signed({34'd0, max_q});
		end else begin
			num = 66'sd1 <<< (2 * FRAC_BITS);
			den = 66'(a_cur);
		end
		un = num[65] ? 64'(-num) : 64'(num);
		ud = den[65] ? DVW'(-den) : DVW'(den);
	end

	assign rem_sh = {rem_q[DVW-1:0], dvd_q[NW-1]};
	assign q_bit  = (rem_sh >= {1'b0, ud_q});

	assign b_val   = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
	assign b_clamp = (b_val > CLAMP) ? CLAMP : ((b_val < -CLAMP) ? -CLAMP : b_val);
	assign sat_b   = aip_pkg::sat32(b_val);
	assign sat_r   = aip_pkg::sat32(64'(rval));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aip_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (!in_data.cmd && in_data.skip) begin
						state_d = aip_pkg::ST_IDLE;
					end else if (in_data.cmd &&
					             (in_data.skip || (subtract_q && max_q == 32'd0))) begin
						state_d = aip_pkg::ST_FIN;
					end else if (complex_q) begin
						state_d = aip_pkg::ST_VEC;
					end else begin
						state_d = aip_pkg::ST_AMP;
					end
				end
			end
			aip_pkg::ST_VEC:  if (cordic_last) state_d = aip_pkg::ST_MA;
			aip_pkg::ST_MA:   state_d = aip_pkg::ST_MAH;
			aip_pkg::ST_MAH:  state_d = aip_pkg::ST_AMP;
			aip_pkg::ST_AMP: begin
				if (!cmd_q) state_d = aip_pkg::ST_IDLE;
				else if (!subtract_q && a_cur == 64'sd0) state_d = aip_pkg::ST_POST;
				else state_d = aip_pkg::ST_DIV;
			end
			aip_pkg::ST_DIV:  if (cnt_q == CW'(NW - 1)) state_d = aip_pkg::ST_POST;
			aip_pkg::ST_POST: state_d = complex_q ? aip_pkg::ST_ROT : aip_pkg::ST_FIN;
			aip_pkg::ST_ROT:  if (cordic_last) state_d = aip_pkg::ST_MX;
			aip_pkg::ST_MX:   state_d = aip_pkg::ST_MXH;
			aip_pkg::ST_MXH:  state_d = aip_pkg::ST_MX2;
			aip_pkg::ST_MX2:  state_d = aip_pkg::ST_MY;
			aip_pkg::ST_MY:   state_d = aip_pkg::ST_MYH;
			aip_pkg::ST_MYH:  state_d = aip_pkg::ST_MY2;
			aip_pkg::ST_MY2:  state_d = aip_pkg::ST_FIN;
			aip_pkg::ST_FIN:  if (out_free) state_d = aip_pkg::ST_IDLE;
			default:          state_d = aip_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = (state_q == aip_pkg::ST_IDLE);
		out_valid = out_valid_q;
		out_data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aip_pkg::ST_IDLE;
			complex_q   <= 1'b0;
			subtract_q  <= 1'b0;
			max_q       <= 32'd0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					aip_pkg::REG_COMPLEX_MODE:  complex_q  <= cfg_wdata;
					aip_pkg::REG_SUBTRACT_MODE: subtract_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == aip_pkg::ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				aip_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire && !in_data.cmd && in_data.first_of_set) max_q <= 32'd0;
				end
				aip_pkg::ST_VEC, aip_pkg::ST_ROT: begin
					cnt_q <= cordic_last ? '0 : cnt_q + CW'(1);
				end
				aip_pkg::ST_AMP: begin
					cnt_q <= '0;
					if (!cmd_q && a_cur > $signed({32'd0, max_q})) begin
						max_q <= (a_cur > 64'sd2147483647) ? 32'h7FFFFFFF : a_cur[31:0];
					end
				end
				aip_pkg::ST_DIV: cnt_q <= cnt_q + CW'(1);
				aip_pkg::ST_POST: cnt_q <= '0;
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			aip_pkg::ST_IDLE: begin
				if (in_fire) begin
					cmd_q  <= in_data.cmd;
					skip_q <= in_data.skip;
					re_q   <= in_data.real_in;
					im_q   <= in_data.imag_in;
					err_q  <= subtract_q && (max_q == 32'd0);
					ro_q   <= in_data.real_in;
					io_q   <= in_data.imag_in;
					sat_q  <= 1'b0;
					if (in_data.real_in < 0) begin
						x_q    <= -W'(in_data.real_in);
						y_q    <= -W'(in_data.imag_in);
						flip_q <= 1'b1;
					end else begin
						x_q    <= W'(in_data.real_in);
						y_q    <= W'(in_data.imag_in);
						flip_q <= 1'b0;
					end
				end
			end
			aip_pkg::ST_VEC: begin
				if (y_q >= 0) begin
					dirs_q[cnt_q[SW-1:0]] <= 1'b1;
					x_q <= x_q + ys;
					y_q <= y_q - xs;
				end else begin
					dirs_q[cnt_q[SW-1:0]] <= 1'b0;
					x_q <= x_q - ys;
					y_q <= y_q + xs;
				end
			end
			aip_pkg::ST_MA, aip_pkg::ST_MX, aip_pkg::ST_MY: begin
				prod_q <= (W+30)'(part_prod);
				sgn_q  <= mul_src[W-1];
			end
			aip_pkg::ST_MAH, aip_pkg::ST_MXH, aip_pkg::ST_MYH: begin
				prod_q <= prod_q + ((W+30)'(part_prod) << ML);
			end
			aip_pkg::ST_AMP: begin
				rem_q <= '0;
				ud_q  <= ud;
				neg_q <= num[65] ^ den[65];
				if (!subtract_q && a_cur == 64'sd0) dvd_q <= '0;
				else dvd_q <= un + 64'(ud >> 1);
			end
			aip_pkg::ST_DIV: begin
				rem_q <= q_bit ? (rem_sh - {1'b0, ud_q}) : rem_sh;
				dvd_q <= {dvd_q[NW-2:0], q_bit};
			end
			aip_pkg::ST_POST: begin
				x_q   <= W'(b_clamp);
				y_q   <= '0;
				ro_q  <= sat_b.val;
				io_q  <= im_q;
				sat_q <= sat_b.clip;
			end
			aip_pkg::ST_ROT: begin
				if (dirs_q[cnt_q[SW-1:0]]) begin
					x_q <= cordic_last && flip_q ? -(x_q - ys) : x_q - ys;
					y_q <= cordic_last && flip_q ? -(y_q + xs) : y_q + xs;
				end else begin
					x_q <= cordic_last && flip_q ? -(x_q + ys) : x_q + ys;
					y_q <= cordic_last && flip_q ? -(y_q - xs) : y_q - xs;
				end
			end
			aip_pkg::ST_MX2: begin
				ro_q  <= sat_r.val;
				sat_q <= sat_r.clip;
			end
			aip_pkg::ST_MY2: begin
				io_q  <= sat_r.val;
				sat_q <= sat_q | sat_r.clip;
			end
			aip_pkg::ST_FIN: begin
				if (out_free) begin
					out_q.real_out       <= ro_q;
					out_q.imag_out       <= io_q;
					out_q.max_zero_error <= err_q;
					out_q.saturated      <= sat_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_max_range: assert property (@(posedge clk) disable iff (!arst_n) !max_q[31])
		else $error("running maximum went negative");
	a_err_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aip_pkg::ST_FIN && (err_q || skip_q)) |-> (ro_q == re_q && !sat_q))
		else $error("masked or error word not passed unchanged");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aip_pkg::ST_DIV) |-> (cnt_q < CW'(NW)))
		else $error("divider step count out of range");
	a_no_scan_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aip_pkg::ST_FIN) |-> cmd_q)
		else $error("scan word reached result stage");
`endif

endmodule

### test/amplitude_invert_polar_unit_tb.sv
// Testbench for the amplitude invert polar unit: scoreboard against a bit-exact predictor.
`timescale 1ns / 1ps
module amplitude_invert_polar_unit_tb;

	localparam int STEPS = 16;
	localparam int FRAC = 16;
	localparam longint AMP_LIM = 64'sd1 << 40;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	aip_pkg::in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	aip_pkg::out_t out_data;

	amplitude_invert_polar_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	// predictor state
	logic [31:0] peak_amp;
	logic cplx_mode;
	logic sub_mode;
	logic [63:0] gain_fix;
	aip_pkg::out_t expected_words[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	int rx_wait = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint mul_gain(longint v, logic [63:0] m);
		logic [63:0] u;
		logic [63:0] r;
		u = (v < 0) ? -v : v;
		r = (u >> 30) * m + (((u & 64'h3FFFFFFF) * m + (64'd1 << 29)) >> 30);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint div_round(longint n, longint d);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] q;
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// vectoring: returns magnitude (raw), direction bits and half-plane flip
	task automatic vectoring(inout longint x, inout longint y, output logic [63:0] dirs,
			output bit flip);
		longint xs;
		longint ys;
		dirs = 0;
		flip = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				dirs[i] = 1'b1;
				x = x + ys;
				y = y - xs;
			end else begin
				x = x - ys;
				y = y + xs;
			end
		end
	endtask

	task automatic rotating(inout longint x, inout longint y, input logic [63:0] dirs,
			input bit flip);
		longint xs;
		longint ys;
		for (int i = 0; i < STEPS; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (dirs[i]) begin
				x = x - ys;
				y = y + xs;
			end else begin
				x = x + ys;
				y = y - xs;
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
	endtask

	function automatic longint clip32(longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	task automatic predict_word(input aip_pkg::in_t w);
		longint re;
		longint im;
		longint x;
		longint y;
		longint amp;
		longint inv;
		longint peak;
		longint one;
		logic [63:0] dirs;
		bit flip;
		aip_pkg::out_t r;
		re = longint'(w.real_in);
		im = longint'(w.imag_in);
		peak = longint'(peak_amp);
		one = 64'sd1 << FRAC;
		if (!w.cmd) begin
			if (w.first_of_set) peak_amp = 0;
			if (!w.skip) begin
				if (cplx_mode) begin
					x = re;
					y = im;
					vectoring(x, y, dirs, flip);
					amp = mul_gain(x, gain_fix);
				end else begin
					amp = re;
				end
				if (amp > longint'(peak_amp))
					peak_amp = (amp > 64'sd2147483647) ? 32'h7FFFFFFF : amp[31:0];
			end
			return;
		end
		r.real_out = w.real_in;
		r.imag_out = w.imag_in;
		r.saturated = 1'b0;
		r.max_zero_error = sub_mode && peak == 0;
		if (!w.skip && !r.max_zero_error) begin
			x = re;
			y = im;
			if (cplx_mode) begin
				vectoring(x, y, dirs, flip);
				amp = mul_gain(x, gain_fix);
			end else begin
				amp = re;
			end
			if (!sub_mode) inv = (amp == 0) ? 0 : div_round(one * one, amp);
			else inv = div_round(10 * one * (peak - amp), peak);
			if (cplx_mode) begin
				if (inv > AMP_LIM) inv = AMP_LIM;
				if (inv < -AMP_LIM) inv = -AMP_LIM;
				x = inv;
				y = 0;
				rotating(x, y, dirs, flip);
				r.real_out = 32'(clip32(mul_gain(x, gain_fix), r.saturated));
				r.imag_out = 32'(clip32(mul_gain(y, gain_fix), r.saturated));
			end else begin
				r.real_out = 32'(clip32(inv, r.saturated));
			end
		end
		expected_words.push_back(r);
	endtask

	// valid stays high into the next word when no gap is drawn
	task automatic send_word(input aip_pkg::in_t w);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		predict_word(w);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: random wait after each word, plus an optional long hold-off
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report("unexpected result word");
			end else begin
				aip_pkg::out_t e;
				e = expected_words.pop_front();
				if (out_data.real_out !== e.real_out)
					report($sformatf("real_out %h exp %h", out_data.real_out, e.real_out));
				if (out_data.imag_out !== e.imag_out)
					report($sformatf("imag_out %h exp %h", out_data.imag_out, e.imag_out));
				if (out_data.max_zero_error !== e.max_zero_error)
					report("max_zero_error mismatch");
				if (out_data.saturated !== e.saturated)
					report("saturated mismatch");
			end
			rx_wait = $urandom_range(0, 6);
		end
		if (hold_off) begin
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait = rx_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == aip_pkg::REG_COMPLEX_MODE) cplx_mode = val;
		else if (idx == aip_pkg::REG_SUBTRACT_MODE) sub_mode = val;
	endtask

	task automatic set_modes(input logic c, input logic s);
		drain();
		write_cfg(aip_pkg::REG_COMPLEX_MODE, c);
		write_cfg(aip_pkg::REG_SUBTRACT_MODE, s);
		// out-of-range index must be ignored
		write_cfg(2'd3, 1'($urandom_range(0, 1)));
		cfg_we <= 1'b0;
	endtask

	function automatic aip_pkg::in_t mk(int c, int f, int s, logic [31:0] re,
			logic [31:0] im);
		aip_pkg::in_t w;
		w.cmd = c[0];
		w.first_of_set = f[0];
		w.skip = s[0];
		w.real_in = re;
		w.imag_in = im;
		return w;
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000);
			2: return -$urandom_range(0, 32'h0004_0000);
			3: return $urandom_range(0, 255);
			4: return {$urandom_range(0, 1) ? 32'h7FFFFF00 : 32'h80000000} | $urandom_range(0, 255);
			default: return $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	task automatic test_directed();
		set_modes(1'b0, 1'b0);
		send_word(mk(1, 0, 0, 32'h0001_0000, 32'h1234));
		send_word(mk(1, 0, 0, 0, 0));
		send_word(mk(1, 0, 0, 1, 32'hFFFF_FFFF));
		send_word(mk(1, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_word(mk(1, 0, 0, 32'h7FFF_FFFF, 0));
		send_word(mk(1, 0, 1, 32'h5555_AAAA, 32'hAAAA_5555));
		set_modes(1'b0, 1'b1);
		send_word(mk(0, 1, 0, 0, 0));
		send_word(mk(1, 0, 0, 32'h0002_0000, 0));
		send_word(mk(0, 0, 0, 32'h0004_0000, 0));
		send_word(mk(0, 0, 1, 32'h7FFF_FFFF, 0));
		send_word(mk(1, 0, 0, 32'h0001_0000, 0));
		send_word(mk(1, 0, 0, 32'h8000_0000, 0));
		send_word(mk(1, 1, 1, 32'h1234_5678, 7));
		set_modes(1'b1, 1'b0);
		send_word(mk(1, 0, 0, 0, 0));
		send_word(mk(1, 0, 0, 32'h8000_0000, 32'h8000_0000));
		send_word(mk(1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(mk(1, 0, 0, 1, 0));
		send_word(mk(1, 0, 0, 32'hFFFF_0000, 32'h0003_0000));
		set_modes(1'b1, 1'b1);
		send_word(mk(0, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(mk(1, 0, 0, 32'h0003_0000, 32'hFFFC_0000));
		send_word(mk(1, 0, 0, 32'h8000_0000, 0));
		send_word(mk(0, 1, 1, 5, 5));
		send_word(mk(1, 0, 0, 5, 5));
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 8; ph++) begin
			set_modes(ph[0], ph[1]);
			for (int k = 0; k < 65; k++) begin
				if (sub_mode && $urandom_range(0, 9) < 8 && k % 15 == 0) begin
					// well-formed set: scan pass then transforms
					for (int j = 0; j < 4; j++)
						send_word(mk(0, int'(j == 0), int'($urandom_range(0, 7) == 0),
							rand_sample(), rand_sample()));
				end
				send_word(mk(int'($urandom_range(0, 4) != 0), int'($urandom_range(0, 1)),
					int'($urandom_range(0, 7) == 0), rand_sample(), rand_sample()));
			end
		end
	endtask

	task automatic test_backpressure();
		set_modes(1'b0, 1'b0);
		hold_off = 1'b1;
		fork
			begin
				for (int k = 0; k < 6; k++) send_word(mk(1, 0, 0, rand_sample(), 0));
			end
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		peak_amp = 0;
		cplx_mode = 0;
		sub_mode = 0;
		gain_fix = ((64'd1 << 60) + aip_pkg::cordic_gain(STEPS) / 2) /
			aip_pkg::cordic_gain(STEPS);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
hw/rtl/aip_pkg.sv
hw/rtl/amplitude_invert_polar_unit.sv
test/amplitude_invert_polar_unit_tb.sv
